>>> rtl/core/hrpi_pkg.sv
package hrpi_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int PERIOD_WIDTH = 16;
   localparam int POS_WIDTH    = 10;
   localparam int SECTOR_SHIFT = 6;
   localparam int QUO_WIDTH    = 7;
   localparam int STEP_WIDTH   = $clog2(QUO_WIDTH);
   localparam int NUM_WIDTH    = COUNT_WIDTH + SECTOR_SHIFT;
   localparam int DVS_WIDTH    = PERIOD_WIDTH + QUO_WIDTH - 1;
   localparam int DIV_WIDTH    = (NUM_WIDTH > DVS_WIDTH) ? NUM_WIDTH : DVS_WIDTH;
   localparam int CMP_WIDTH    = COUNT_WIDTH + PERIOD_WIDTH + 2;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PERIOD_WIDTH-1:0] TIMEOUT_RESET = PERIOD_WIDTH'(5000);
   localparam logic [QCNT_WIDTH-1:0]   QUEUE_FULL    = QCNT_WIDTH'(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] coarse;
      logic [COUNT_WIDTH-1:0]      ticks;
      logic [PERIOD_WIDTH-1:0]     period;
      logic                        divide;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic signed [POS_WIDTH-1:0] sector_start(input logic [2:0] pattern);
      logic signed [POS_WIDTH-1:0] pos;
      case (pattern)
         3'b000:  pos = '1;
         3'b001:  pos = POS_WIDTH'(0);
         3'b010:  pos = POS_WIDTH'(128);
         3'b011:  pos = POS_WIDTH'(64);
         3'b100:  pos = POS_WIDTH'(256);
         3'b101:  pos = POS_WIDTH'(320);
         3'b110:  pos = POS_WIDTH'(192);
         3'b111:  pos = POS_WIDTH'(0);
         default: pos = POS_WIDTH'(0);
      endcase
      return pos;
   endfunction

endpackage

>>> rtl/core/hrpi_channels.sv
interface hrpi_req_if;
   logic valid;
   logic ready;
   logic hall_a;
   logic hall_b;
   logic hall_c;

   modport source (output valid, output hall_a, output hall_b, output hall_c, input ready);
   modport sink (input valid, input hall_a, input hall_b, input hall_c, output ready);
endinterface

interface hrpi_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [hrpi_pkg::POS_WIDTH-1:0] coarse_position;
   logic signed [hrpi_pkg::POS_WIDTH-1:0] fine_position;
   logic                                  interpolated;
   logic [hrpi_pkg::PERIOD_WIDTH-1:0]     edge_period;

   modport source (output valid, output coarse_position, output fine_position,
                   output interpolated, output edge_period, input ready);
   modport sink (input valid, input coarse_position, input fine_position,
                 input interpolated, input edge_period, output ready);
endinterface

interface hrpi_csr_if;
   logic                              valid;
   logic                              ready;
   logic [hrpi_pkg::PERIOD_WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/hrpi_front.sv
module hrpi_front (
   input  logic                                clock,
   input  logic                                reset,
   hrpi_req_if.sink                            req_chan,
   input  logic [hrpi_pkg::PERIOD_WIDTH-1:0]   timeout,
   input  hrpi_pkg::queue_status_type          q_status,
   output logic                                push,
   output hrpi_pkg::job_type                   job
);

   logic [2:0]                             pattern;
   logic [2:0]                             prev_ff, prev_in;
   logic [hrpi_pkg::COUNT_WIDTH-1:0]       ticks_ff, ticks_in;
   logic [hrpi_pkg::PERIOD_WIDTH-1:0]      period_ff, period_in;
   logic                                   running_ff, running_in;
   logic [hrpi_pkg::COUNT_WIDTH-1:0]       elapsed;
   logic [hrpi_pkg::CMP_WIDTH-1:0]         twice_ticks;
   logic [hrpi_pkg::CMP_WIDTH-1:0]         thrice_period;
   logic                                   usable;

   assign pattern        = {req_chan.hall_c, req_chan.hall_b, req_chan.hall_a};
   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      elapsed    = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;
      prev_in    = prev_ff;
      ticks_in   = ticks_ff;
      period_in  = period_ff;
      running_in = running_ff;
      if (pattern != prev_ff) begin
         if (running_ff) begin
            period_in = hrpi_pkg::PERIOD_WIDTH'(elapsed);
         end
         ticks_in   = '0;
         running_in = 1'b1;
         prev_in    = pattern;
      end else begin
         ticks_in = elapsed;
         if (hrpi_pkg::CMP_WIDTH'(elapsed) > hrpi_pkg::CMP_WIDTH'(timeout)) begin
            period_in  = '0;
            running_in = 1'b0;
         end
      end
   end

   always_comb begin
      twice_ticks   = hrpi_pkg::CMP_WIDTH'(ticks_in) << 1;
      thrice_period = (hrpi_pkg::CMP_WIDTH'(period_in) << 1) + hrpi_pkg::CMP_WIDTH'(period_in);
      usable        = (period_in != '0) && (period_in < timeout);
      job.coarse    = hrpi_pkg::sector_start(pattern);
      job.ticks     = ticks_in;
      job.period    = period_in;
      job.divide    = usable && (twice_ticks < thrice_period);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         ticks_ff   <= '0;
         period_ff  <= '0;
         running_ff <= 1'b0;
      end else if (push) begin
         prev_ff    <= prev_in;
         ticks_ff   <= ticks_in;
         period_ff  <= period_in;
         running_ff <= running_in;
      end
   end

endmodule

>>> rtl/core/hrpi_queue.sv
module hrpi_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hrpi_pkg::job_type          push_data,
   input  logic                       pop,
   output hrpi_pkg::job_type          pop_data,
   output hrpi_pkg::queue_status_type status
);

   hrpi_pkg::job_type                 mem [hrpi_pkg::QUEUE_DEPTH];
   logic [hrpi_pkg::QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [hrpi_pkg::QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [hrpi_pkg::QCNT_WIDTH-1:0]   count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == hrpi_pkg::QUEUE_FULL);
   assign pop_data     = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == hrpi_pkg::QPTR_WIDTH'(hrpi_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == hrpi_pkg::QPTR_WIDTH'(hrpi_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/hrpi_back.sv
module hrpi_back (
   input  logic                       clock,
   input  logic                       reset,
   input  hrpi_pkg::queue_status_type q_status,
   input  hrpi_pkg::job_type          pop_data,
   output logic                       pop,
   hrpi_rsp_if.source                 rsp_chan
);

   hrpi_pkg::back_state_type               state_ff, state_in;
   hrpi_pkg::job_type                      job_ff;
   logic [hrpi_pkg::DIV_WIDTH-1:0]         rem_ff;
   logic [hrpi_pkg::DIV_WIDTH-1:0]         dvs_ff;
   logic [hrpi_pkg::QUO_WIDTH-1:0]         quo_ff;
   logic [hrpi_pkg::STEP_WIDTH-1:0]        step_ff;
   logic                                   last_step;
   logic                                   fits;

   assign last_step = (step_ff == hrpi_pkg::STEP_WIDTH'(hrpi_pkg::QUO_WIDTH - 1));
   assign fits      = (rem_ff >= dvs_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hrpi_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = pop_data.divide ? hrpi_pkg::BK_DIVIDE : hrpi_pkg::BK_DONE;
            end
         end
         hrpi_pkg::BK_DIVIDE: begin
            if (last_step) begin
               state_in = hrpi_pkg::BK_DONE;
            end
         end
         hrpi_pkg::BK_DONE: begin
            if (rsp_chan.ready) begin
               state_in = hrpi_pkg::BK_IDLE;
            end
         end
         default: state_in = hrpi_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop                      = (state_ff == hrpi_pkg::BK_IDLE) && !q_status.empty;
      rsp_chan.valid           = (state_ff == hrpi_pkg::BK_DONE);
      rsp_chan.coarse_position = job_ff.coarse;
      rsp_chan.fine_position   = job_ff.divide ?
                                 job_ff.coarse + signed'(hrpi_pkg::POS_WIDTH'(quo_ff)) :
                                 job_ff.coarse;
      rsp_chan.interpolated    = job_ff.divide;
      rsp_chan.edge_period     = job_ff.period;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff  <= pop_data;
         rem_ff  <= hrpi_pkg::DIV_WIDTH'(pop_data.ticks) << hrpi_pkg::SECTOR_SHIFT;
         dvs_ff  <= hrpi_pkg::DIV_WIDTH'(pop_data.period) << (hrpi_pkg::QUO_WIDTH - 1);
         quo_ff  <= '0;
         step_ff <= '0;
      end else if (state_ff == hrpi_pkg::BK_DIVIDE) begin
         if (fits) begin
            rem_ff <= rem_ff - dvs_ff;
         end
         quo_ff  <= {quo_ff[hrpi_pkg::QUO_WIDTH-2:0], fits};
         dvs_ff  <= dvs_ff >> 1;
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrpi_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/hall_rotor_position_interpolator.sv
// channel   | direction | fields
// ----------+-----------+------------------------------------------------------
// req_chan  | in        | hall_a, hall_b, hall_c (one tick per transfer)
// rsp_chan  | out       | coarse_position, fine_position, interpolated, edge_period
// csr_chan  | in        | data = stall_timeout_ticks
//
// The front end takes a tick every cycle while the two-entry job queue has room.
// Without interpolation the back end answers directly; with it, it divides first:
// the shared divider runs one quotient bit per cycle for 7 bits.
// Synchronous reset clears the sensor state, queue and back end; timeout is 5000.
// A stalled result holds the back end; the front keeps filling the queue.
module hall_rotor_position_interpolator (
   input  logic      clock,
   input  logic      reset,
   hrpi_req_if.sink  req_chan,
   hrpi_rsp_if.source rsp_chan,
   hrpi_csr_if.sink  csr_chan
);

   logic [hrpi_pkg::PERIOD_WIDTH-1:0] timeout_ff;
   hrpi_pkg::queue_status_type        q_status;
   hrpi_pkg::job_type                 push_data;
   hrpi_pkg::job_type                 pop_data;
   logic                              push;
   logic                              pop;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= hrpi_pkg::TIMEOUT_RESET;
      end else if (csr_chan.valid) begin
         timeout_ff <= csr_chan.data;
      end
   end

   hrpi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .timeout  (timeout_ff),
      .q_status (q_status),
      .push     (push),
      .job      (push_data)
   );

   hrpi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   hrpi_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   a_fallback_is_coarse: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.interpolated |->
         rsp_chan.fine_position == rsp_chan.coarse_position)
      else $error("fine position differs from coarse without interpolation");

   a_interp_needs_period: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.interpolated |-> rsp_chan.edge_period != '0)
      else $error("interpolated result with zero period");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("transfer accepted into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("pop from an empty queue");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result presented right after reset");

endmodule
